@@ sv/cpd_pkg.sv @@
// cpd_pkg: shared types, codes and constants of the current presence detector
// no dependencies; imported by every module of the block except cpd_ram
`default_nettype none

package cpd_pkg;

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 10;
    localparam int COUNT_W    = 4;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int RPT_CNT_W  = 4;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FORCE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD  = 2'd1;

    // reset values and limits
    localparam logic [COUNT_W-1:0]   COUNT_RESET     = 4'd0;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET = 10'd36;
    localparam logic [RPT_CNT_W-1:0] MAX_REPORTS     = 4'd8;

    // input beat
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_beat_t;

    // output beat
    typedef struct packed {
        logic [CHAN_W-1:0] report_channel;
        logic              is_on;
        logic              last_report;
    } out_beat_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_WALK_RD,
        ST_WALK_EVAL,
        ST_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic walk;
        logic capture;
        logic ram_wr;
        logic set_force;
        logic walk_start;
        logic commit;
        logic idx_inc;
        logic hold_load;
        logic hold_to_out;
        logic out_last;
        logic win_clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sample_ok;
        logic force_ok;
        logic close;
        logic walk_done;
        logic need_report;
        logic cap_ok;
        logic hold_valid;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/current_presence_detector.sv @@
// current_presence_detector: sample beat reads memory, then writes min/max back; force
// and ignored beats stay in idle; window close reads, then evaluates, each active channel,
// then flushes, paced by the single min/max memory read port; it waits on output stalls.
// a new input beat is taken while a finished report waits in the output register.
// reset (rst_n, async, active low) clears flags and valid bits at once: the min/max
// memory is marked empty through per-channel valid bits, with no clearing pass.
`default_nettype none

module current_presence_detector
    import cpd_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_beat_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_beat_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    cpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpd_datapath #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

@@ sv/cpd_ram.sv @@
// cpd_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module cpd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]             wr_data,
    input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/cpd_ctrl.sv @@
// cpd_ctrl: controller state machine of the current presence detector
// depends on cpd_pkg for states, command and status structs
`default_nettype none

module cpd_ctrl
    import cpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // ready is high here, so a valid beat is taken this cycle
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.sample_ok)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_UPDATE;
                    end
                    else if (stat.force_ok)
                    begin
                        cmd.set_force = 1'b1;
                    end
                    else if (stat.close)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK_RD;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.ram_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK_RD:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_WALK_EVAL;
                end
            end
            ST_WALK_EVAL:
            begin
                cmd.walk = 1'b1;
                if (!stat.need_report || !stat.cap_ok || !stat.hold_valid)
                begin
                    // nothing to push out, or the hold slot is free
                    cmd.commit    = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.hold_load = stat.need_report && stat.cap_ok;
                    state_next    = ST_WALK_RD;
                end
                else if (stat.out_free)
                begin
                    // older report moves to the output, this one takes the hold slot
                    cmd.commit      = 1'b1;
                    cmd.idx_inc     = 1'b1;
                    cmd.hold_load   = 1'b1;
                    cmd.hold_to_out = 1'b1;
                    state_next      = ST_WALK_RD;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.hold_valid)
                begin
                    cmd.win_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.hold_to_out = 1'b1;
                    cmd.out_last    = 1'b1;
                    cmd.win_clear   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/cpd_datapath.sv @@
// cpd_datapath: config registers, min/max memory, channel flags and output stage
// depends on cpd_pkg and cpd_ram
`default_nettype none

module cpd_datapath
    import cpd_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire in_beat_t              in_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output out_beat_t                  out_data,
    input  wire cmd_t                  cmd,
    output stat_t                      stat
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(CHANNELS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SW     = SAMPLE_BITS;
    localparam int SPAN_W = (SW > THR_W) ? SW : THR_W;

    logic [COUNT_W-1:0]  chan_count_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [CMP_W-1:0]    n_active;
    logic                ch_active;

    logic [CH_W-1:0]     cap_ch_reg;
    logic [SW-1:0]       cap_smp_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CH_W-1:0]     idx_ch;
    logic [CH_W-1:0]     in_ch;

    logic [CH_W-1:0]     rd_addr;
    logic [2*SW-1:0]     rd_data;
    logic [SW-1:0]       cur_min;
    logic [SW-1:0]       cur_max;
    logic [SW-1:0]       new_min;
    logic [SW-1:0]       new_max;
    logic                upd_valid;

    logic [CHANNELS-1:0] win_valid_reg;
    logic [CHANNELS-1:0] reported_reg;
    logic [CHANNELS-1:0] prev_reg;
    logic [CHANNELS-1:0] force_reg;

    logic                reading_on;
    logic                need_report;

    logic [RPT_CNT_W-1:0] rpt_cnt_reg;
    logic                 hold_valid_reg;
    logic [CHAN_W-1:0]    hold_ch_reg;
    logic                 hold_on_reg;
    logic                 out_valid_reg;
    out_beat_t            out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= COUNT_RESET;
            thr_reg        <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_ON_THRESHOLD:  thr_reg        <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    // active channel count, saturated at the number of channels built
    always_comb
    begin
        if (CMP_W'(chan_count_reg) > CMP_W'(CHANNELS))
        begin
            n_active = CMP_W'(CHANNELS);
        end
        else
        begin
            n_active = CMP_W'(chan_count_reg);
        end
    end

    // decode of the beat on the input port
    assign in_ch          = CH_W'(in_data.channel);
    assign ch_active      = CMP_W'(in_data.channel) < n_active;
    assign stat.sample_ok = (in_data.action == ACT_SAMPLE) && ch_active;
    assign stat.force_ok  = (in_data.action == ACT_FORCE) && ch_active;
    assign stat.close     = (in_data.action == ACT_CLOSE);

    // captured sample beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_ch_reg  <= in_ch;
            cap_smp_reg <= SW'(in_data.sample);
        end
    end

    // walk index over active channels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.walk_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign idx_ch         = idx_reg[CH_W-1:0];
    assign stat.walk_done = (CMP_W'(idx_reg) == n_active);

    // min/max memory, max in the upper half
    assign rd_addr = cmd.walk ? idx_ch : in_ch;

    cpd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (CHANNELS)
    ) u_minmax_ram (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (cap_ch_reg),
        .wr_data ({new_max, new_min}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_min = rd_data[SW-1:0];
    assign cur_max = rd_data[2*SW-1:SW];

    // sample update; an entry without its valid bit is an empty window
    assign upd_valid = win_valid_reg[cap_ch_reg];
    assign new_min   = (!upd_valid || (cap_smp_reg < cur_min)) ? cap_smp_reg : cur_min;
    assign new_max   = (!upd_valid || (cap_smp_reg > cur_max)) ? cap_smp_reg : cur_max;

    // window valid bits, all dropped when the window closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= '0;
        end
        else if (cmd.win_clear)
        begin
            win_valid_reg <= '0;
        end
        else if (cmd.ram_wr)
        begin
            win_valid_reg[cap_ch_reg] <= 1'b1;
        end
    end

    // reading of the channel under the walk index
    assign reading_on = win_valid_reg[idx_ch] &&
                        ((SPAN_W'(cur_max) - SPAN_W'(cur_min)) > SPAN_W'(thr_reg));
    assign need_report = ((reading_on == prev_reg[idx_ch]) &&
                          (reading_on != reported_reg[idx_ch])) || force_reg[idx_ch];
    assign stat.need_report = need_report;

    // per-channel debounce and force flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= '0;
            prev_reg     <= '0;
            force_reg    <= '0;
        end
        else if (cmd.set_force)
        begin
            force_reg[in_ch] <= 1'b1;
        end
        else if (cmd.commit)
        begin
            prev_reg[idx_ch] <= reading_on;
            if (need_report)
            begin
                reported_reg[idx_ch] <= reading_on;
                force_reg[idx_ch]    <= 1'b0;
            end
        end
    end

    // reports handed out during this close
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_cnt_reg <= '0;
        end
        else if (cmd.walk_start)
        begin
            rpt_cnt_reg <= '0;
        end
        else if (cmd.hold_load)
        begin
            rpt_cnt_reg <= rpt_cnt_reg + 1'b1;
        end
    end

    assign stat.cap_ok = (rpt_cnt_reg < MAX_REPORTS);

    // hold slot: a report waits here until the next one or the walk end shows
    // whether it is the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (cmd.hold_load)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (cmd.hold_to_out)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            hold_ch_reg <= CHAN_W'(idx_reg);
            hold_on_reg <= reading_on;
        end
    end

    assign stat.hold_valid = hold_valid_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.hold_to_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_to_out)
        begin
            out_data_reg.report_channel <= hold_ch_reg;
            out_data_reg.is_on          <= hold_on_reg;
            out_data_reg.last_report    <= cmd.out_last;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

`default_nettype wire

@@ sv/cpd_checker.sv @@
// cpd_checker: port-level assertions for the current presence detector
// depends on cpd_pkg; bound to current_presence_detector below
`default_nettype none

module cpd_checker
    import cpd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire in_beat_t              in_data,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire out_beat_t             out_data,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // a window close always starts a walk, so input is held off next cycle
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.action == ACT_CLOSE) |=> !in_ready)
        else $error("input taken right after a window close");

    // force requests finish in the accepting cycle
    a_force_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.action == ACT_FORCE) |=> in_ready)
        else $error("force request stalled the input");

    // reports only come out of a walk, never while idle
    a_out_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("report appeared while idle");

endmodule

bind current_presence_detector cpd_checker u_cpd_checker (.*);

`default_nettype wire
